@@ hw/rtl/rcsc_pkg.sv @@
// Shared types and constants for the RC stick and mode switch conditioner.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package rcsc_pkg;

    localparam int PULSE_BITS_DEF  = 12;
    localparam int DZ_BITS         = 9;
    localparam int GAIN_BITS       = 32;
    localparam int THR_BITS        = 12;
    localparam int LEVEL_BITS      = 16;
    localparam int APB_DATA_BITS   = 32;
    localparam int APB_ADDR_BITS   = 5;
    localparam int REG_IDX_BITS    = 3;

    localparam int CENTER_US       = 1500;
    localparam int SWITCH_LIMIT_US = 2100;
    localparam int LEVEL_MAX       = 32767;

    localparam logic [DZ_BITS-1:0]   DZ_RST     = DZ_BITS'(25);
    localparam logic [GAIN_BITS-1:0] GAIN_RST   = GAIN_BITS'(4521018);
    localparam logic [THR_BITS-1:0]  THR_RST    = THR_BITS'(1750);

    typedef enum logic [REG_IDX_BITS-1:0] {
        REG_DEAD_ZONE  = 3'd0,
        REG_STICK_GAIN = 3'd1,
        REG_MODE_THR   = 3'd2,
        REG_GEAR_THR   = 3'd3,
        REG_REBOOT_THR = 3'd4
    } t_reg_idx;

    typedef struct packed {
        logic [DZ_BITS-1:0]   dz_half;
        logic [GAIN_BITS-1:0] gain;
        logic [THR_BITS-1:0]  mode_thr;
        logic [THR_BITS-1:0]  gear_thr;
        logic [THR_BITS-1:0]  reboot_thr;
    } t_cfg;

    typedef struct packed {
        logic hover_entered;
        logic hover_active;
        logic command_entered;
        logic command_active;
        logic reboot_toggled;
        logic out_of_range;
    } t_sw_flags;

endpackage

`default_nettype wire

@@ hw/rtl/rcsc_cfg_regs.sv @@
// APB register file: dead zone, stick gain and the three switch thresholds.
// Depends on rcsc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rcsc_cfg_regs (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  psel,
    input  wire                                  penable,
    input  wire                                  pwrite,
    input  wire  [rcsc_pkg::APB_ADDR_BITS-1:0]   paddr,
    input  wire  [rcsc_pkg::APB_DATA_BITS-1:0]   pwdata,
    output logic [rcsc_pkg::APB_DATA_BITS-1:0]   prdata,
    output logic                                 pready,
    output rcsc_pkg::t_cfg                       o_cfg
);
    import rcsc_pkg::*;

    t_cfg                    r_cfg;
    logic                    wr_en;
    logic [REG_IDX_BITS-1:0] reg_idx;

    // word index; byte offset bits are ignored
    assign reg_idx = paddr[APB_ADDR_BITS-1:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.dz_half    <= DZ_RST;
            r_cfg.gain       <= GAIN_RST;
            r_cfg.mode_thr   <= THR_RST;
            r_cfg.gear_thr   <= THR_RST;
            r_cfg.reboot_thr <= THR_RST;
        end else if (wr_en) begin
            case (reg_idx)
                REG_DEAD_ZONE:  r_cfg.dz_half    <= pwdata[DZ_BITS-1:0];
                REG_STICK_GAIN: r_cfg.gain       <= pwdata[GAIN_BITS-1:0];
                REG_MODE_THR:   r_cfg.mode_thr   <= pwdata[THR_BITS-1:0];
                REG_GEAR_THR:   r_cfg.gear_thr   <= pwdata[THR_BITS-1:0];
                REG_REBOOT_THR: r_cfg.reboot_thr <= pwdata[THR_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_DEAD_ZONE:  prdata = APB_DATA_BITS'(r_cfg.dz_half);
            REG_STICK_GAIN: prdata = APB_DATA_BITS'(r_cfg.gain);
            REG_MODE_THR:   prdata = APB_DATA_BITS'(r_cfg.mode_thr);
            REG_GEAR_THR:   prdata = APB_DATA_BITS'(r_cfg.gear_thr);
            REG_REBOOT_THR: prdata = APB_DATA_BITS'(r_cfg.reboot_thr);
            default:        prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

@@ hw/rtl/rcsc_stick_lane.sv @@
// One stick channel: center at 1500 us, dead zone, gain multiply, saturate.
// Depends on rcsc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rcsc_stick_lane #(
    parameter int PULSE_BITS = rcsc_pkg::PULSE_BITS_DEF
) (
    input  wire         [PULSE_BITS-1:0]              i_pulse,
    input  wire         [rcsc_pkg::DZ_BITS-1:0]       i_dz_half,
    input  wire         [rcsc_pkg::GAIN_BITS-1:0]     i_gain,
    output logic signed [rcsc_pkg::LEVEL_BITS-1:0]    o_level,
    output logic                                      o_inside
);
    import rcsc_pkg::*;

    localparam int PROD_BITS = PULSE_BITS + GAIN_BITS;
    localparam logic [PULSE_BITS-1:0] CENTER = PULSE_BITS'(CENTER_US);

    logic                       neg;
    logic [PULSE_BITS-1:0]      mag;
    logic [PULSE_BITS-1:0]      dz_ext;
    logic [PULSE_BITS-1:0]      excess;
    logic [PROD_BITS-1:0]       prod;
    logic                       sat;
    logic [LEVEL_BITS-1:0]      q;

    assign neg      = i_pulse < CENTER;
    assign mag      = neg ? (CENTER - i_pulse) : (i_pulse - CENTER);
    assign dz_ext   = PULSE_BITS'(i_dz_half);
    assign o_inside = mag <= dz_ext;
    assign excess   = mag - dz_ext;
    assign prod     = PROD_BITS'(excess) * PROD_BITS'(i_gain);
    // (prod >> 16) above 32767 whenever any bit from 31 up is set
    assign sat      = |prod[PROD_BITS-1:31];
    assign q        = sat ? LEVEL_BITS'(LEVEL_MAX) : {1'b0, prod[30:16]};

    always_comb begin
        if (o_inside) begin
            o_level = '0;
        end else if (neg) begin
            o_level = -$signed(q);
        end else begin
            o_level = $signed(q);
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/rcsc_switch_logic.sv @@
// Mode, gear and reboot switch decoding with edge history and sticky command entry.
// Depends on rcsc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rcsc_switch_logic #(
    parameter int PULSE_BITS = rcsc_pkg::PULSE_BITS_DEF
) (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_advance,
    input  rcsc_pkg::t_cfg           i_cfg,
    input  wire  [PULSE_BITS-1:0]    i_mode_pulse,
    input  wire  [PULSE_BITS-1:0]    i_gear_pulse,
    input  wire  [PULSE_BITS-1:0]    i_reboot_pulse,
    output rcsc_pkg::t_sw_flags      o_flags
);
    import rcsc_pkg::*;

    localparam int CMP_W = (PULSE_BITS > THR_BITS) ? PULSE_BITS : THR_BITS;
    localparam logic [CMP_W-1:0] LIMIT = CMP_W'(SWITCH_LIMIT_US);

    logic                  r_primed;
    logic [PULSE_BITS-1:0] r_prev_mode;
    logic [PULSE_BITS-1:0] r_prev_gear;
    logic [PULSE_BITS-1:0] r_prev_reboot;
    logic                  r_cmd;
    logic                  r_cmd_entry;
    logic                  n_cmd;
    logic                  n_cmd_entry;

    logic [CMP_W-1:0] mode, gear, reboot;
    logic [CMP_W-1:0] p_mode, p_gear, p_reboot;
    logic [CMP_W-1:0] mode_thr, gear_thr, reboot_thr;
    logic             hover;

    assign mode       = CMP_W'(i_mode_pulse);
    assign gear       = CMP_W'(i_gear_pulse);
    assign reboot     = CMP_W'(i_reboot_pulse);
    // first frame after reset sees itself as history: no edges
    assign p_mode     = r_primed ? CMP_W'(r_prev_mode)   : mode;
    assign p_gear     = r_primed ? CMP_W'(r_prev_gear)   : gear;
    assign p_reboot   = r_primed ? CMP_W'(r_prev_reboot) : reboot;
    assign mode_thr   = CMP_W'(i_cfg.mode_thr);
    assign gear_thr   = CMP_W'(i_cfg.gear_thr);
    assign reboot_thr = CMP_W'(i_cfg.reboot_thr);

    assign hover = mode > mode_thr;

    always_comb begin
        n_cmd       = r_cmd;
        n_cmd_entry = r_cmd_entry;
        if (hover) begin
            if (p_gear < gear_thr && gear > gear_thr) begin
                n_cmd_entry = 1'b1;
            end else if (gear < gear_thr) begin
                n_cmd_entry = 1'b0;
            end
            n_cmd = gear > gear_thr;
        end
    end

    always_comb begin
        o_flags.hover_entered   = (p_mode < mode_thr) && hover;
        o_flags.hover_active    = hover;
        o_flags.command_entered = n_cmd_entry;
        o_flags.command_active  = n_cmd;
        o_flags.reboot_toggled  = !hover && !n_cmd &&
                                  (p_reboot < reboot_thr) && (reboot > reboot_thr);
        o_flags.out_of_range    = (mode > LIMIT) || (gear > LIMIT) || (reboot > LIMIT);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_primed    <= 1'b0;
            r_cmd       <= 1'b1;
            r_cmd_entry <= 1'b0;
        end else if (i_advance) begin
            r_primed    <= 1'b1;
            r_cmd       <= n_cmd;
            r_cmd_entry <= n_cmd_entry;
        end
    end

    // history only matters once primed
    always_ff @(posedge i_clk) begin
        if (i_advance) begin
            r_prev_mode   <= i_mode_pulse;
            r_prev_gear   <= i_gear_pulse;
            r_prev_reboot <= i_reboot_pulse;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/rc_stick_and_mode_switch_conditioner_top.sv @@
// Top level of the RC stick and mode switch conditioner.
// Depends on rcsc_pkg, rcsc_cfg_regs, rcsc_stick_lane, rcsc_switch_logic.
//
// Usage:
//   Input channel: one beat is one radio frame (four stick pulses and the
//   mode, gear and reboot switch pulses, in us), taken when i_in_valid is
//   high and o_in_stall is low. Output channel: one beat per frame with the
//   four Q1.15 stick levels and the mode flags, taken when o_out_valid is
//   high and i_out_stall is low.
//   The frame is registered in the input register, then all levels and flags
//   are computed in one pass into the result register. Throughput is one
//   frame per cycle while i_out_stall is low; the four per-stick multipliers
//   and the switch history update all finish within that single pass.
//   While the receiver stalls, the result register holds and one more frame
//   may wait in the input register; o_in_stall rises only when both are full.
//   Synchronous reset restores register defaults, empties both stages and
//   invalidates the switch history; the first frame after reset primes it.
//   Write registers over APB only while no frame is in flight; not enforced.
`timescale 1ns / 1ps
`default_nettype none

module rc_stick_and_mode_switch_conditioner_top #(
    parameter int PULSE_BITS = rcsc_pkg::PULSE_BITS_DEF
) (
    input  wire                                       i_clk,
    input  wire                                       i_rst_n,
    // APB configuration
    input  wire                                       psel,
    input  wire                                       penable,
    input  wire                                       pwrite,
    input  wire         [rcsc_pkg::APB_ADDR_BITS-1:0] paddr,
    input  wire         [rcsc_pkg::APB_DATA_BITS-1:0] pwdata,
    output logic        [rcsc_pkg::APB_DATA_BITS-1:0] prdata,
    output logic                                      pready,
    // frame input
    input  wire                                       i_in_valid,
    output logic                                      o_in_stall,
    input  wire         [PULSE_BITS-1:0]              i_stick0_pulse,
    input  wire         [PULSE_BITS-1:0]              i_stick1_pulse,
    input  wire         [PULSE_BITS-1:0]              i_stick2_pulse,
    input  wire         [PULSE_BITS-1:0]              i_stick3_pulse,
    input  wire         [PULSE_BITS-1:0]              i_mode_pulse,
    input  wire         [PULSE_BITS-1:0]              i_gear_pulse,
    input  wire         [PULSE_BITS-1:0]              i_reboot_pulse,
    // result output
    output logic                                      o_out_valid,
    input  wire                                       i_out_stall,
    output logic signed [rcsc_pkg::LEVEL_BITS-1:0]    o_stick0_level,
    output logic signed [rcsc_pkg::LEVEL_BITS-1:0]    o_stick1_level,
    output logic signed [rcsc_pkg::LEVEL_BITS-1:0]    o_stick2_level,
    output logic signed [rcsc_pkg::LEVEL_BITS-1:0]    o_stick3_level,
    output logic                                      o_hover_entered,
    output logic                                      o_hover_active,
    output logic                                      o_command_entered,
    output logic                                      o_command_active,
    output logic                                      o_reboot_toggled,
    output logic                                      o_sticks_centered,
    output logic                                      o_out_of_range
);
    import rcsc_pkg::*;

    localparam int NUM_STICKS = 4;

    t_cfg cfg;

    logic                  r_in_valid;
    logic [PULSE_BITS-1:0] r_stick [NUM_STICKS];
    logic [PULSE_BITS-1:0] r_mode;
    logic [PULSE_BITS-1:0] r_gear;
    logic [PULSE_BITS-1:0] r_reboot;

    logic                  in_accept;
    logic                  advance;

    logic signed [LEVEL_BITS-1:0] level  [NUM_STICKS];
    logic        [NUM_STICKS-1:0] lane_in_dz;
    t_sw_flags                    flags;

    logic                         r_out_valid;
    logic signed [LEVEL_BITS-1:0] r_level [NUM_STICKS];
    t_sw_flags                    r_flags;
    logic                         r_centered;

    rcsc_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // handshake: stage 1 moves on when the result register is empty or drained
    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && r_out_valid && i_out_stall;
    assign in_accept  = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_stick[0] <= i_stick0_pulse;
            r_stick[1] <= i_stick1_pulse;
            r_stick[2] <= i_stick2_pulse;
            r_stick[3] <= i_stick3_pulse;
            r_mode     <= i_mode_pulse;
            r_gear     <= i_gear_pulse;
            r_reboot   <= i_reboot_pulse;
        end
    end

    for (genvar g = 0; g < NUM_STICKS; g++) begin : g_lane
        rcsc_stick_lane #(
            .PULSE_BITS (PULSE_BITS)
        ) u_lane (
            .i_pulse     (r_stick[g]),
            .i_dz_half   (cfg.dz_half),
            .i_gain      (cfg.gain),
            .o_level     (level[g]),
            .o_inside    (lane_in_dz[g])
        );
    end

    rcsc_switch_logic #(
        .PULSE_BITS (PULSE_BITS)
    ) u_switch (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_advance      (advance),
        .i_cfg          (cfg),
        .i_mode_pulse   (r_mode),
        .i_gear_pulse   (r_gear),
        .i_reboot_pulse (r_reboot),
        .o_flags        (flags)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_level    <= level;
            r_flags    <= flags;
            r_centered <= &lane_in_dz;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_stick0_level    = r_level[0];
    assign o_stick1_level    = r_level[1];
    assign o_stick2_level    = r_level[2];
    assign o_stick3_level    = r_level[3];
    assign o_hover_entered   = r_flags.hover_entered;
    assign o_hover_active    = r_flags.hover_active;
    assign o_command_entered = r_flags.command_entered;
    assign o_command_active  = r_flags.command_active;
    assign o_reboot_toggled  = r_flags.reboot_toggled;
    assign o_sticks_centered = r_centered;
    assign o_out_of_range    = r_flags.out_of_range;

endmodule

`default_nettype wire

@@ hw/rtl/rcsc_checker.sv @@
// Port-level checks for the conditioner top level, attached by bind.
// Depends on rcsc_pkg and rc_stick_and_mode_switch_conditioner_top.
`timescale 1ns / 1ps
`default_nettype none

module rcsc_checker (
    input wire                                       i_clk,
    input wire                                       i_rst_n,
    input wire                                       o_in_stall,
    input wire                                       o_out_valid,
    input wire                                       i_out_stall,
    input wire signed [rcsc_pkg::LEVEL_BITS-1:0]     o_stick0_level,
    input wire signed [rcsc_pkg::LEVEL_BITS-1:0]     o_stick1_level,
    input wire signed [rcsc_pkg::LEVEL_BITS-1:0]     o_stick2_level,
    input wire signed [rcsc_pkg::LEVEL_BITS-1:0]     o_stick3_level,
    input wire                                       o_hover_entered,
    input wire                                       o_hover_active,
    input wire                                       o_command_active,
    input wire                                       o_reboot_toggled,
    input wire                                       o_sticks_centered
);
    import rcsc_pkg::*;

    // a held result keeps its levels
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_stick0_level) &&
        $stable(o_stick1_level) && $stable(o_stick2_level) && $stable(o_stick3_level))
        else $error("result changed while stalled");

    // input side only backs up when the result register is full and stalled
    a_in_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled with free result register");

    a_hover_edge: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_hover_entered |-> o_hover_active)
        else $error("hover entry without hover level");

    a_reboot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_reboot_toggled |-> !o_hover_active && !o_command_active)
        else $error("reboot toggle while a mode is active");

    a_centered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_sticks_centered |-> o_stick0_level == '0 &&
        o_stick1_level == '0 && o_stick2_level == '0 && o_stick3_level == '0)
        else $error("centered flag with nonzero stick level");

endmodule

bind rc_stick_and_mode_switch_conditioner_top rcsc_checker u_rcsc_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .o_in_stall        (o_in_stall),
    .o_out_valid       (o_out_valid),
    .i_out_stall       (i_out_stall),
    .o_stick0_level    (o_stick0_level),
    .o_stick1_level    (o_stick1_level),
    .o_stick2_level    (o_stick2_level),
    .o_stick3_level    (o_stick3_level),
    .o_hover_entered   (o_hover_entered),
    .o_hover_active    (o_hover_active),
    .o_command_active  (o_command_active),
    .o_reboot_toggled  (o_reboot_toggled),
    .o_sticks_centered (o_sticks_centered)
);

`default_nettype wire
